// File: src/ypr_pkg.sv
package ypr_pkg;

  // Width of the signed intermediate sums; every reachable sum lies well
  // inside +/- 2^18.
  localparam int SumW = 20;
  localparam int PixW = 8;
  localparam int FracW = 8;

  localparam logic signed [SumW-1:0] LumaOfs   = SumW'(16);
  localparam logic signed [SumW-1:0] ChromaOfs = SumW'(128);
  localparam logic signed [SumW-1:0] RoundOfs  = SumW'(128);

  localparam logic signed [SumW-1:0] CoefY  = SumW'(298);
  localparam logic signed [SumW-1:0] CoefRv = SumW'(409);
  localparam logic signed [SumW-1:0] CoefGu = SumW'(100);
  localparam logic signed [SumW-1:0] CoefGv = SumW'(208);
  localparam logic signed [SumW-1:0] CoefBu = SumW'(516);

  localparam logic signed [SumW-1:0] ChanMax = SumW'(255);

  // Chroma contributions shared by both pixels of a pair.
  typedef struct packed {
    logic signed [SumW-1:0] red_term;
    logic signed [SumW-1:0] green_term;
    logic signed [SumW-1:0] blue_term;
  } chroma_terms_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } rgb_t;

  // Floor division by 256 followed by a clamp to 0..255.
  function automatic logic [PixW-1:0] clamp_channel(input logic signed [SumW-1:0] sum);
    logic signed [SumW-1:0] scaled;
    scaled = sum >>> FracW;
    if (scaled < 0) begin
      return '0;
    end else if (scaled > ChanMax) begin
      return ChanMax[PixW-1:0];
    end
    return scaled[PixW-1:0];
  endfunction

endpackage

// File: src/ypr_in_if.sv
interface ypr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_second;
  logic [7:0] chroma_u;
  logic [7:0] luma_first;
  logic [7:0] chroma_v;
  logic       last_pair;

  modport source (
    output valid, luma_second, chroma_u, luma_first, chroma_v, last_pair,
    input  ready
  );
  modport sink (
    input  valid, luma_second, chroma_u, luma_first, chroma_v, last_pair,
    output ready
  );
endinterface

// File: src/ypr_out_if.sv
interface ypr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic       last_out;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, last_out,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, last_out,
    output ready
  );
endinterface

// File: src/ypr_chroma.sv
module ypr_chroma
  import ypr_pkg::*;
(
  input  logic [PixW-1:0] chroma_u,
  input  logic [PixW-1:0] chroma_v,
  output chroma_terms_t   terms
);

  logic signed [SumW-1:0] d_val;
  logic signed [SumW-1:0] e_val;

  assign d_val = $signed(SumW'(chroma_u)) - ChromaOfs;
  assign e_val = $signed(SumW'(chroma_v)) - ChromaOfs;

  // The rounding offset is folded into the shared terms.
  assign terms.red_term   = CoefRv * e_val + RoundOfs;
  assign terms.green_term = RoundOfs - CoefGu * d_val - CoefGv * e_val;
  assign terms.blue_term  = CoefBu * d_val + RoundOfs;

endmodule

// File: src/ypr_pixel.sv
module ypr_pixel
  import ypr_pkg::*;
(
  input  logic [PixW-1:0] luma,
  input  chroma_terms_t   terms,
  output rgb_t            rgb
);

  logic signed [SumW-1:0] luma_term;

  assign luma_term = CoefY * ($signed(SumW'(luma)) - LumaOfs);

  assign rgb.red   = clamp_channel(luma_term + terms.red_term);
  assign rgb.green = clamp_channel(luma_term + terms.green_term);
  assign rgb.blue  = clamp_channel(luma_term + terms.blue_term);

endmodule

// File: src/yuyv_pair_to_rgb.sv
//  Channel  | Direction | Payload                                   | Handshake
//  in_pair  | input     | luma_second, chroma_u, luma_first,        | valid/ready
//           |           | chroma_v, last_pair                       |
//  out_rgb  | output    | red/green/blue of first and second pixel, | valid/ready
//           |           | last_out                                  |
//
//  Each pair passes through the input register and then the result
//  register, with the color arithmetic between them. One transaction
//  can be taken every cycle while out_rgb does not stall; the rate is set
//  by the two register stages, each of which refills in the cycle it empties.
//  Reset (rst_n low, synchronous) empties both stages; payload is not reset.
//  A stall on out_rgb holds the result register and, once the input register
//  is also full, deasserts in_pair.ready.
module yuyv_pair_to_rgb
  import ypr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ypr_in_if.sink    in_pair,
  ypr_out_if.source out_rgb
);

  // Input register stage.
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic [PixW-1:0] s1_luma_first_r;
  logic [PixW-1:0] s1_luma_second_r;
  logic [PixW-1:0] s1_chroma_u_r;
  logic [PixW-1:0] s1_chroma_v_r;
  logic            s1_last_r;

  // Result register stage.
  logic            s2_valid_r;
  logic            s2_valid_nxt;
  rgb_t            s2_first_r;
  rgb_t            s2_second_r;
  logic            s2_last_r;

  logic            in_acc;
  logic            s2_free;
  logic            s1_move;

  chroma_terms_t   terms;
  rgb_t            first_rgb;
  rgb_t            second_rgb;

  // The result register can take new data when it is empty or its
  // transaction completes this cycle. The input register can take a new
  // transaction when it is empty or its content moves forward.
  assign s2_free       = !s2_valid_r || out_rgb.ready;
  assign s1_move       = s1_valid_r && s2_free;
  assign in_pair.ready = !s1_valid_r || s2_free;
  assign in_acc        = in_pair.valid && in_pair.ready;

  assign s1_valid_nxt = in_acc || (s1_valid_r && !s2_free);
  assign s2_valid_nxt = s1_valid_r || (s2_valid_r && !out_rgb.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma_first_r  <= in_pair.luma_first;
      s1_luma_second_r <= in_pair.luma_second;
      s1_chroma_u_r    <= in_pair.chroma_u;
      s1_chroma_v_r    <= in_pair.chroma_v;
      s1_last_r        <= in_pair.last_pair;
    end
  end

  // Chroma products are computed once and shared by both pixels.
  ypr_chroma u_chroma (
    .chroma_u (s1_chroma_u_r),
    .chroma_v (s1_chroma_v_r),
    .terms    (terms)
  );

  ypr_pixel u_pixel_first (
    .luma  (s1_luma_first_r),
    .terms (terms),
    .rgb   (first_rgb)
  );

  ypr_pixel u_pixel_second (
    .luma  (s1_luma_second_r),
    .terms (terms),
    .rgb   (second_rgb)
  );

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_first_r  <= first_rgb;
      s2_second_r <= second_rgb;
      s2_last_r   <= s1_last_r;
    end
  end

  assign out_rgb.valid        = s2_valid_r;
  assign out_rgb.red_first    = s2_first_r.red;
  assign out_rgb.green_first  = s2_first_r.green;
  assign out_rgb.blue_first   = s2_first_r.blue;
  assign out_rgb.red_second   = s2_second_r.red;
  assign out_rgb.green_second = s2_second_r.green;
  assign out_rgb.blue_second  = s2_second_r.blue;
  assign out_rgb.last_out     = s2_last_r;

  // Reset leaves no transaction on the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_rgb.valid)
    else $error("result valid after reset");

  // An accepted transaction always lands in the input register.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost at input register");

  // A pair that moves forward shows up as a result next cycle.
  a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_rgb.valid)
    else $error("moved pair did not reach the result register");

  // The frame-end flag travels with its pair.
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_rgb.last_out == $past(s1_last_r))
    else $error("last flag not carried with its pair");

endmodule
